FILE: hdl/sbdc_pkg.sv
// Shared types and constants for the divisor-count sorter.
// No dependencies.
`default_nettype none
package sbdc_pkg;
    localparam int VAL_W = 31;
    localparam int CNT_W = 11;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last_in;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] sorted_value;
        logic [CNT_W-1:0] divisor_count;
        logic             last_out;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZERO,
        ST_DIV,
        ST_DIVWAIT,
        ST_REDIV,
        ST_NEXT,
        ST_FINAL,
        ST_DONE
    } t_dc_state;

    typedef enum logic [2:0] {
        SS_LOAD,
        SS_SCAN_RD,
        SS_SCAN_CHK,
        SS_EMIT_RD,
        SS_EMIT_OUT
    } t_so_state;
endpackage
`default_nettype wire

FILE: hdl/sbdc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sbdc_pkg.
`default_nettype none
module sbdc_divider (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [sbdc_pkg::VAL_W-1:0] i_num,
    input  wire logic [sbdc_pkg::VAL_W-1:0] i_den,
    output logic                         o_done,
    output logic [sbdc_pkg::VAL_W-1:0]   o_quot,
    output logic [sbdc_pkg::VAL_W-1:0]   o_rem
);
    import sbdc_pkg::*;

    logic [VAL_W-1:0] r_quot, r_den;
    logic [VAL_W-1:0] r_rem;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   shifted;

    assign shifted = {r_rem, r_quot[VAL_W-1]};
    assign trial   = shifted - {1'b0, r_den};

    // Shift one numerator bit in per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(VAL_W - 1);
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!trial[VAL_W]) begin
                    r_rem  <= trial[VAL_W-1:0];
                    r_quot <= {r_quot[VAL_W-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted[VAL_W-1:0];
                    r_quot <= {r_quot[VAL_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: hdl/sbdc_counter.sv
// Divisor counter: trial division over a single serial divider.
// Depends on sbdc_pkg and sbdc_divider.
`default_nettype none
module sbdc_counter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sbdc_pkg::VAL_W-1:0] i_value,
    output logic                            o_done,
    output logic [sbdc_pkg::CNT_W-1:0]      o_count
);
    import sbdc_pkg::*;

    t_dc_state        r_state, n_state;
    logic [VAL_W-1:0] r_rest, r_d;
    logic [CNT_W-1:0] r_total;
    logic [5:0]       r_exp;
    logic [31:0]      r_sq;
    logic             div_start, div_done;
    logic [VAL_W-1:0] div_q, div_r;
    logic [CNT_W+5:0] prod;

    sbdc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_rest), .i_den(r_d), .o_done(div_done),
        .o_quot(div_q), .o_rem(div_r)
    );

    assign prod = r_total * ({1'b0, r_exp} + 7'd1);

    // Next state
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: if (i_start) n_state = (i_value == '0) ? ST_ZERO : ST_NEXT;
            ST_ZERO: n_state = ST_DONE;
            ST_NEXT: begin
                // d*d > rest ends the search (2 and 3 always tried)
                if (r_d > 31'd3 && r_sq > {1'b0, r_rest}) n_state = ST_FINAL;
                else begin
                    div_start = 1'b1;
                    n_state   = ST_DIVWAIT;
                end
            end
            ST_DIVWAIT: if (div_done) n_state = (div_r == '0) ? ST_REDIV : ST_DIV;
            // Divide the reduced value again by the same candidate
            ST_REDIV: begin
                div_start = 1'b1;
                n_state   = ST_DIVWAIT;
            end
            ST_DIV:   n_state = ST_NEXT;
            ST_FINAL: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
        case (r_state)
            ST_IDLE: begin
                r_rest  <= i_value;
                r_d     <= 31'd2;
                r_sq    <= 32'd4;
                r_total <= 11'd1;
                r_exp   <= '0;
            end
            ST_ZERO: r_total <= '0;
            ST_DIVWAIT: if (div_done && div_r == '0) begin
                r_rest <= div_q;
                r_exp  <= r_exp + 6'd1;
            end
            ST_DIV: begin
                // fold exponent in, move to next candidate
                r_total <= prod[CNT_W-1:0];
                r_exp   <= '0;
                if (r_d == 31'd2) begin
                    r_d <= 31'd3;  r_sq <= 32'd9;
                end else if (r_d == 31'd3) begin
                    r_d <= 31'd5;  r_sq <= 32'd25;
                end else begin
                    r_d  <= r_d + 31'd2;
                    r_sq <= r_sq + {r_d[29:0], 2'b00} + 32'd4;
                end
            end
            ST_FINAL: if (r_rest > 31'd1) r_total <= {r_total[CNT_W-2:0], 1'b0};
            default: ;
        endcase
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_count = r_total;
endmodule
`default_nettype wire

FILE: hdl/stable_sort_by_divisor_count.sv
`default_nettype none
// Stable sort by divisor count.
// Input channel: i_in_valid/o_in_ready carry t_in_item {value, last_in}.
// Output channel: o_out_valid/i_out_ready carry t_out_item.
// Each item's divisor count is found by trial division on a serial
// divider, with one more division for each repeated exact division;
// up to about sqrt(value)/2 trial divisors are tried, and zero skips them.
// The value and count are written to a 64-entry memory in arrival order.
// After the last item (or when the store fills) results are emitted by
// repeated passes: for each count level one pass over the entries finds
// the next-highest count and another emits the entries that have it.
// Equal counts leave in arrival order.
// Reset empties the store; memory contents need no clearing.
// A stalled receiver holds the output register and pauses the emit pass;
// no item is accepted until the set's last result is loaded into the output register.
module stable_sort_by_divisor_count #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire sbdc_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output sbdc_pkg::t_out_item       o_out_item
);
    import sbdc_pkg::*;
    localparam int AW = $clog2(MAX_ITEMS);

    logic [VAL_W+CNT_W-1:0] mem [MAX_ITEMS];
    logic [VAL_W+CNT_W-1:0] r_rd;
    logic [AW-1:0]  r_addr;
    logic [AW:0]    r_n, r_idx, r_emitted;
    logic [CNT_W:0] r_cur, r_best;
    logic           r_busy, r_last, r_found;
    t_so_state      r_st;
    t_out_item      r_out;
    logic           r_ov;
    logic           cnt_done;
    logic [CNT_W-1:0] cnt_val;
    logic [VAL_W-1:0] r_val;
    logic           acc;
    logic           emit_match, emit_fire;

    assign acc = i_in_valid && o_in_ready;
    assign o_in_ready = !r_busy && r_st == SS_LOAD;

    // Load the output register when the current entry belongs to this level and the output is free
    assign emit_match = ({1'b0, r_rd[CNT_W-1:0]} == r_best);
    assign emit_fire  = (r_st == SS_EMIT_OUT) && emit_match && (!r_ov || i_out_ready);

    sbdc_counter u_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(acc),
        .i_value(i_in_item.value), .o_done(cnt_done), .o_count(cnt_val)
    );

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (cnt_done) mem[r_n[AW-1:0]] <= {r_val, cnt_val};
        r_rd <= mem[r_addr];
    end

    // Control: load, then repeated scans for each count level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_n <= '0; r_st <= SS_LOAD; r_ov <= 1'b0;
        end else begin
            if (emit_fire) r_ov <= 1'b1;
            else if (r_ov && i_out_ready) r_ov <= 1'b0;
            case (r_st)
                SS_LOAD: begin
                    if (acc) begin
                        r_busy <= 1'b1;
                        r_val  <= i_in_item.value;
                        r_last <= i_in_item.last_in;
                    end else if (cnt_done) begin
                        r_n    <= r_n + 1'b1;
                        if (r_last || r_n + 1'b1 == (AW+1)'(MAX_ITEMS)) begin
                            r_st <= SS_SCAN_RD;
                            r_cur <= {1'b1, {CNT_W{1'b0}}};
                            r_emitted <= '0;
                            r_idx <= '0; r_addr <= '0;
                            r_found <= 1'b0; r_best <= '0;
                        end else begin
                            r_busy <= 1'b0;
                        end
                    end
                end
                // Find the largest count below r_cur
                SS_SCAN_RD: r_st <= SS_SCAN_CHK;
                SS_SCAN_CHK: begin
                    if ({1'b0, r_rd[CNT_W-1:0]} < r_cur &&
                        (!r_found || {1'b0, r_rd[CNT_W-1:0]} > r_best)) begin
                        r_best  <= {1'b0, r_rd[CNT_W-1:0]};
                        r_found <= 1'b1;
                    end
                    if (r_idx + 1'b1 == r_n) begin
                        r_idx <= '0; r_addr <= '0; r_st <= SS_EMIT_RD;
                    end else begin
                        r_idx  <= r_idx + 1'b1;
                        r_addr <= AW'(r_idx + 1'b1);
                        r_st   <= SS_SCAN_RD;
                    end
                end
                SS_EMIT_RD: r_st <= SS_EMIT_OUT;
                // Emit every entry whose count equals r_best, in order
                SS_EMIT_OUT: begin
                    if (emit_match) begin
                        if (emit_fire) begin
                            r_out.sorted_value  <= r_rd[VAL_W+CNT_W-1:CNT_W];
                            r_out.divisor_count <= r_rd[CNT_W-1:0];
                            r_out.last_out      <= (r_emitted + 1'b1 == r_n);
                            r_emitted <= r_emitted + 1'b1;
                            if (r_emitted + 1'b1 == r_n) begin
                                r_st <= SS_LOAD; r_busy <= 1'b0; r_n <= '0;
                            end else if (r_idx + 1'b1 == r_n) begin
                                r_cur <= r_best; r_found <= 1'b0; r_best <= '0;
                                r_idx <= '0; r_addr <= '0; r_st <= SS_SCAN_RD;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                                r_addr <= AW'(r_idx + 1'b1);
                                r_st <= SS_EMIT_RD;
                            end
                        end
                    end else if (r_idx + 1'b1 == r_n) begin
                        r_cur <= r_best; r_found <= 1'b0; r_best <= '0;
                        r_idx <= '0; r_addr <= '0; r_st <= SS_SCAN_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_addr <= AW'(r_idx + 1'b1);
                        r_st <= SS_EMIT_RD;
                    end
                end
                default: r_st <= SS_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for stable_sort_by_divisor_count: directed sets, random sets, a full store and a pause.
// Depends on sbdc_pkg for the item structs; predicts each set's sorted output itself.
module tb_top;
    import sbdc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    stable_sort_by_divisor_count dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    localparam int STORE_DEPTH = 64;

    t_out_item        sorted_q[$];
    logic [VAL_W-1:0] pending_vals[$];
    int               send_idle_pct;
    int               recv_stall_pct;
    int               mismatches;
    int               results_seen;
    int               items_sent;
    int               sets_closed;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count divisors by trial division: 2, 3, then odd candidates up to the root
    function automatic int divisor_total(logic [VAL_W-1:0] v);
        longint unsigned rest;
        longint unsigned d;
        int              total;
        int              e;
        rest = {33'd0, v};
        if (rest == 0) return 0;
        e = 0;
        while (rest % 2 == 0) begin
            rest = rest / 2;
            e++;
        end
        total = e + 1;
        e = 0;
        while (rest % 3 == 0) begin
            rest = rest / 3;
            e++;
        end
        total = total * (e + 1);
        for (d = 5; d * d <= rest; d += 2) begin
            e = 0;
            while (rest % d == 0) begin
                rest = rest / d;
                e++;
            end
            total = total * (e + 1);
        end
        if (rest > 1) total = total * 2;
        return total;
    endfunction

    // Close the pending set: stable sort by count, most first, into the expected queue
    task automatic close_set();
        t_out_item ordered[$];
        t_out_item r;
        int        j;
        for (int i = 0; i < pending_vals.size(); i++) begin
            r.sorted_value  = pending_vals[i];
            r.divisor_count = CNT_W'(divisor_total(pending_vals[i]));
            r.last_out      = 1'b0;
            j = ordered.size();
            while (j > 0 && ordered[j-1].divisor_count < r.divisor_count) j--;
            ordered.insert(j, r);
        end
        ordered[ordered.size()-1].last_out = 1'b1;
        foreach (ordered[i]) sorted_q.push_back(ordered[i]);
        pending_vals.delete();
        sets_closed++;
    endtask

    // Send one item, with a random idle gap first
    task automatic send_item(logic [VAL_W-1:0] v, logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{value: v, last_in: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        pending_vals.push_back(v);
        if (last || pending_vals.size() == STORE_DEPTH) close_set();
    endtask

    // Drop valid and hold until every expected result has come
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Check each accepted result against the oldest expectation; drive stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d count %0d last %0b",
                             o_out_item.sorted_value, o_out_item.divisor_count,
                             o_out_item.last_out);
            end else begin
                if (o_out_item !== sorted_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %0d count %0d last %0b, got %0d %0d %0b",
                                 sorted_q[0].sorted_value, sorted_q[0].divisor_count,
                                 sorted_q[0].last_out, o_out_item.sorted_value,
                                 o_out_item.divisor_count, o_out_item.last_out);
                end
                void'(sorted_q.pop_front());
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = 31'd1;
            7, 8, 9: v = VAL_W'($urandom_range(1, 4095)) << $urandom_range(0, 19);
            default: v = VAL_W'($urandom_range(2, 5000));
        endcase
        return v;
    endfunction

    // Extremes, zero, one, wide values and equal-count stability
    task automatic test_directed();
        send_item(31'd0, 1'b0); send_item(31'd1, 1'b0); send_item(31'd2, 1'b0);
        send_item(31'd3, 1'b0); send_item(31'd4, 1'b1);
        send_item(31'h7FFF_FFFE, 1'b0); send_item(31'h4000_0000, 1'b0);
        send_item(31'd720720, 1'b0); send_item(31'd65521, 1'b0); send_item(31'd12, 1'b1);
        send_item(31'd1, 1'b1);
        send_item(31'd6, 1'b0); send_item(31'd10, 1'b0); send_item(31'd14, 1'b0);
        send_item(31'd15, 1'b1);
        send_item(31'd0, 1'b1);
        drain();
    endtask

    // Fill the store without a last flag; it must close by itself
    task automatic test_full_store();
        for (int k = 0; k < STORE_DEPTH; k++) send_item(random_value(), 1'b0);
        send_item(31'd7, 1'b1);
        drain();
    endtask

    // Random sets, mostly short, now and then long
    task automatic test_random_sets(int n_items);
        int size;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STORE_DEPTH)
                                                : $urandom_range(1, 6);
            for (int k = 0; k < size; k++)
                send_item(random_value(), (k == size - 1) ? 1'b1 : 1'b0);
            sent += size;
        end
        drain();
    endtask

    // Hold the sender until all expected results are out, then resume
    task automatic test_pause();
        send_item(31'd360, 1'b0); send_item(31'd97, 1'b1);
        i_in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        send_item(31'd30, 1'b0); send_item(31'd5040, 1'b1);
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        results_seen   = 0;
        items_sent     = 0;
        sets_closed    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random_sets(100);
        send_idle_pct = 67; recv_stall_pct = 0;
        test_random_sets(100);
        test_pause();
        send_idle_pct = 0;  recv_stall_pct = 67;
        test_random_sets(100);
        send_idle_pct = 29; recv_stall_pct = 29;
        test_random_sets(100);

        $display("Ran %0d items in %0d sets, %0d results checked, %0d mismatches.",
                 items_sent, sets_closed, results_seen, mismatches);
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
